// ===== rtl/core/b64c_pkg.sv =====
// b64c_pkg: shared constants, queue entry type and alphabet functions
// for the base64 crypt/mime codec; depends on nothing
`timescale 1ns / 1ps

package b64c_pkg;

  localparam logic [2:0] MODE_MIME_ENC  = 3'd0;
  localparam logic [2:0] MODE_CRYPT_ENC = 3'd1;
  localparam logic [2:0] MODE_SWAP_ENC  = 3'd2;
  localparam logic [2:0] MODE_CRYPT_DEC = 3'd3;
  localparam logic [2:0] MODE_SWAP_DEC  = 3'd4;

  localparam int unsigned QueueDepth = 2;

  // one finished group, handed from front to back
  typedef struct packed {
    logic [2:0]  mode;
    logic [23:0] bits;
    logic [2:0]  cnt;   // results to emit, 1 to 4
    logic        last;
    logic        dang;
  } grp_t;

  function automatic logic [7:0] mime_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26) return 8'h41 + w;
      else if (v < 6'd52) return 8'h61 + w - 8'd26;
      else if (v < 6'd62) return 8'h30 + w - 8'd52;
      else if (v == 6'd62) return 8'h2b;
      else return 8'h2f;
    end
  endfunction

  function automatic logic [7:0] crypt_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v == 6'd0) return 8'h2e;
      else if (v == 6'd1) return 8'h2f;
      else if (v < 6'd12) return 8'h30 + w - 8'd2;
      else if (v < 6'd38) return 8'h41 + w - 8'd12;
      else return 8'h61 + w - 8'd38;
    end
  endfunction

  function automatic logic [5:0] crypt_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      if (c == 8'h2e) t = 8'd0;
      else if (c == 8'h2f) t = 8'd1;
      else if (c >= 8'h30 && c <= 8'h39) t = c - 8'h2e;
      else if (c >= 8'h41 && c <= 8'h5a) t = c - 8'h35;
      else t = c + 8'd5;   // lowercase rule, wraps modulo 64
      return t[5:0];
    end
  endfunction

endpackage

// ===== rtl/core/b64c_if.sv =====
// b64c_if: valid/ready stream interfaces for the codec's input and result
// channels; payload widths are fixed, no package dependency
`timescale 1ns / 1ps

interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       last_in;

  modport source (output valid, output data_in, output last_in, input ready);
  modport sink (input valid, input data_in, input last_in, output ready);
endinterface

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;
  logic       dangling;

  modport source (output valid, output data_out, output last_out, output dangling,
                  input ready);
  modport sink (input valid, input data_out, input last_out, input dangling,
                output ready);
endinterface

// ===== rtl/core/base64_crypt_mime_codec_core.sv =====
// base64_crypt_mime_codec_core: top level of the streaming base64 codec;
// uses b64c_pkg, b64c_if, b64c_front, b64c_queue and b64c_back
`timescale 1ns / 1ps

// Streaming base64 codec. The 3-bit mode register, written through cfg_we and
// cfg_data, selects mime encode (0), crypt encode msb first (1), crypt encode
// lsb first (2), crypt decode msb first (3) or crypt decode lsb first (4); a
// write also drops any partial group, so write it only while the block is idle.
// Modes 5 to 7 swallow items and give nothing. Encoding turns every 3 bytes
// into 4 characters, a final 1-byte tail into 2 and a 2-byte tail into 3, with
// no padding. Decoding turns every 4 characters into 3 bytes, tails of 2 or 3
// characters into 1 or 2 bytes, and a single leftover character into one
// result with dangling set, data zero and last_out set. The front takes one
// item every cycle while the two-entry group queue has room; the back emits
// one result per cycle from its output register while the output is not
// stalled. Encode intake is thus held back by the back end, since every 3 bytes
// give 4 results, while decode intake keeps pace with the front. The first
// result of a group passes the queue register, then the output register.

module base64_crypt_mime_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  b64c_in_if.sink    in_s,
  b64c_out_if.source out_m
);

  // front to queue
  logic           q_full, q_push;
  b64c_pkg::grp_t q_wr_entry;
  // queue to back
  logic           q_pop, q_nonempty;
  b64c_pkg::grp_t q_rd_entry;

  // front: mode register and group gathering
  b64c_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .in_data  (in_s.data_in),
    .in_last  (in_s.last_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wr_entry)
  );

  // short queue decouples item intake from result delivery
  b64c_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .nonempty (q_nonempty)
  );

  // back: one result per cycle into the output register while the output is not stalled
  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_entry    (q_rd_entry),
    .q_pop      (q_pop),
    .out_valid  (out_m.valid),
    .out_ready  (out_m.ready),
    .out_data   (out_m.data_out),
    .out_last   (out_m.last_out),
    .out_dang   (out_m.dangling)
  );

endmodule

// ===== rtl/core/b64c_front.sv =====
// b64c_front: mode register, item accept and group gathering; pushes each
// finished group into the queue; uses b64c_pkg
`timescale 1ns / 1ps

module b64c_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output b64c_pkg::grp_t    q_entry
);

  logic [2:0]  mode_r;
  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  count_r, pos;
  logic [2:0]  held;
  logic [4:0]  sh;
  logic [5:0]  v;
  logic        is_enc, is_dec, accept, done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_enc   = (mode_r <= b64c_pkg::MODE_SWAP_ENC);
  assign is_dec   = (mode_r == b64c_pkg::MODE_CRYPT_DEC) ||
                    (mode_r == b64c_pkg::MODE_SWAP_DEC);
  assign v        = b64c_pkg::crypt_value(in_data);

  always_comb begin
    pos      = count_r;
    sh       = 5'd0;
    bits_nxt = bits_r;
    done     = 1'b0;
    q_entry  = '0;
    if (is_enc) begin
      if (pos == 2'd3) pos = 2'd2;
      if (mode_r == b64c_pkg::MODE_SWAP_ENC) sh = {pos, 3'b000};
      else sh = 5'd16 - {pos, 3'b000};
      bits_nxt = bits_r | ({16'd0, in_data} << sh);
      held     = {1'b0, pos} + 3'd1;
      done     = (held == 3'd3) || in_last;
      q_entry.cnt = held + 3'd1;
    end else begin
      case (pos)
        2'd0: sh = 5'd0;
        2'd1: sh = 5'd6;
        2'd2: sh = 5'd12;
        default: sh = 5'd18;
      endcase
      if (mode_r != b64c_pkg::MODE_SWAP_DEC) sh = 5'd18 - sh;
      bits_nxt = bits_r | ({18'd0, v} << sh);
      held     = {1'b0, pos} + 3'd1;
      done     = (held == 3'd4) || in_last;
      q_entry.dang = (held == 3'd1);
      q_entry.cnt  = (held == 3'd1) ? 3'd1 : held - 3'd1;
    end
    q_entry.mode = mode_r;
    q_entry.bits = q_entry.dang ? 24'd0 : bits_nxt;
    q_entry.last = in_last;
  end

  assign q_push = accept && (is_enc || is_dec) && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= b64c_pkg::MODE_MIME_ENC;
      bits_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      mode_r  <= cfg_data;
      bits_r  <= '0;
      count_r <= '0;
    end else if (accept && (is_enc || is_dec)) begin
      if (done) begin
        bits_r  <= '0;
        count_r <= '0;
      end else begin
        bits_r  <= bits_nxt;
        count_r <= held[1:0];
      end
    end
  end

endmodule

// ===== rtl/core/b64c_queue.sv =====
// b64c_queue: two-entry register queue of finished groups between front
// and back; uses b64c_pkg
`timescale 1ns / 1ps

module b64c_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64c_pkg::grp_t wr_entry,
  output logic           full,
  input  logic           pop,
  output b64c_pkg::grp_t rd_entry,
  output logic           nonempty
);

  localparam int unsigned CntW = $clog2(b64c_pkg::QueueDepth + 1);
  localparam int unsigned PtrW = $clog2(b64c_pkg::QueueDepth);

  b64c_pkg::grp_t   slot_r [b64c_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  cnt_r;

  assign full     = (cnt_r == CntW'(b64c_pkg::QueueDepth));
  assign nonempty = (cnt_r != '0);
  assign rd_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(b64c_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(b64c_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/core/b64c_back.sv =====
// b64c_back: splits each queued group into its results, one a cycle while the
// output is not stalled, into the output register; uses b64c_pkg
`timescale 1ns / 1ps

module b64c_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  b64c_pkg::grp_t q_entry,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_data,
  output logic           out_last,
  output logic           out_dang
);

  logic [1:0]  idx_r;
  logic        valid_r;
  logic [7:0]  data_r, data_nxt;
  logic        last_r, dang_r;
  logic        load, final_res;
  logic [4:0]  sh;
  logic [23:0] shifted;

  assign load      = q_nonempty && (!valid_r || out_ready);
  assign final_res = (({1'b0, idx_r} + 3'd1) == q_entry.cnt);
  assign q_pop     = load && final_res;

  always_comb begin
    sh       = 5'd0;
    data_nxt = 8'd0;
    case (q_entry.mode) inside
      b64c_pkg::MODE_MIME_ENC, b64c_pkg::MODE_CRYPT_ENC, b64c_pkg::MODE_SWAP_ENC: begin
        case (idx_r)
          2'd0: sh = 5'd0;
          2'd1: sh = 5'd6;
          2'd2: sh = 5'd12;
          default: sh = 5'd18;
        endcase
        if (q_entry.mode != b64c_pkg::MODE_SWAP_ENC) sh = 5'd18 - sh;
      end
      default: begin
        sh = {idx_r, 3'b000};
        if (q_entry.mode != b64c_pkg::MODE_SWAP_DEC) sh = 5'd16 - sh;
      end
    endcase
    shifted = q_entry.bits >> sh;
    case (q_entry.mode) inside
      b64c_pkg::MODE_MIME_ENC: data_nxt = b64c_pkg::mime_char(shifted[5:0]);
      b64c_pkg::MODE_CRYPT_ENC, b64c_pkg::MODE_SWAP_ENC:
        data_nxt = b64c_pkg::crypt_char(shifted[5:0]);
      default: data_nxt = shifted[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= final_res ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      last_r <= q_entry.last && final_res;
      dang_r <= q_entry.dang;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_dang  = dang_r;

endmodule

// ===== rtl/core/b64c_checker.sv =====
// b64c_checker: port-level assertions for the codec top level, attached by
// bind; depends only on the top level's ports
`timescale 1ns / 1ps

module b64c_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       out_last,
  input logic       dangling
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) &&
      $stable(out_last) && $stable(dangling))
    else $error("result changed while stalled");

  // dangling result is the zero-data end of its message
  a_dang_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dangling |-> out_last && (out_data == 8'd0))
    else $error("dangling result malformed");

  // reset empties the output side
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the queue, so the input is open right after
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind base64_crypt_mime_codec_core b64c_checker u_b64c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_data  (out_m.data_out),
  .out_last  (out_m.last_out),
  .dangling  (out_m.dangling)
);
